@@ hw/rtl/tst_pkg.sv @@
// Shared types, codes and defaults for the timer slot table.
package tst_pkg;

  localparam int TST_SLOT_COUNT = 16;

  // input operation codes (carried on in_tuser)
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  // result kinds (carried on out_tuser)
  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_EXPIRY    = 3'd2;
  localparam logic [2:0] KIND_IDLE_TICK = 3'd3;
  localparam logic [2:0] KIND_RELEASED  = 3'd4;

  typedef struct packed {
    logic [7:0]  ticks;
    logic [15:0] owner;
    logic [2:0]  action;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

@@ hw/rtl/tst_slot_ram.sv @@
// Slot entry memory: one write port, one read port with registered data.
module tst_slot_ram
  import tst_pkg::*;
#(
  parameter int DEPTH = TST_SLOT_COUNT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/timer_slot_table.sv @@
// Top level of the timer slot table.
//
// Input stream: in_tuser carries the operation (schedule, tick, release),
// in_tdata the owner id, delay and action code. One item is taken at a time;
// in_tready is high only while the block is idle.
// Output stream: out_tuser carries the result kind, out_tlast marks the final
// result of an item, out_tdata carries slot index, owner, action and count.
// A schedule scans the armed bits one slot per cycle up to the first free
// slot. A tick or a release walks every slot through the single read port of
// the slot memory, one slot per cycle pipelined with the read; a tick's walk
// is held while it stalls, as below.
// A tick with several expiries holds its walk whenever a finished expiry
// cannot move into the output register; a stalled receiver stretches the
// item by the stall time and no result is lost.
// Reset clears the per-slot armed bits, so every slot is free
// right after reset and no memory clearing pass is needed. The output
// register holds a result until it is taken.
module timer_slot_table
  import tst_pkg::*;
#(
  parameter int SLOT_COUNT = TST_SLOT_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] owner_id, [23:16] delay_ticks, [26:24] action_code
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] slot_index, [19:4] expired_owner,
                                  // [22:20] expired_action, [27:23] released_count
  output logic [2:0]  out_tuser,  // [2:0] result_kind
  output logic        out_tlast   // last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        owner_r, owner_nxt;
  logic [7:0]         delay_r, delay_nxt;
  logic [2:0]         action_r, action_nxt;
  logic [SLOT_COUNT-1:0] armed_r, armed_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]   ev_idx_r, ev_idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               full_r, full_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [15:0]        pend_owner_r, pend_owner_nxt;
  logic [2:0]         pend_action_r, pend_action_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [2:0]         out_kind_r, out_kind_nxt;
  logic [3:0]         out_slot_r, out_slot_nxt;
  logic [15:0]        out_owner_r, out_owner_nxt;
  logic [2:0]         out_action_r, out_action_nxt;
  logic [4:0]         out_cnt_r, out_cnt_nxt;
  logic               out_last_r, out_last_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_rdata;

  logic               out_free;
  logic               in_xfer;
  logic               scan_end;
  logic               scan_busy;
  logic               ev_armed;
  logic               tick_hit;
  logic               stall;

  tst_slot_ram #(
    .DEPTH(SLOT_COUNT),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .rd_en(mem_rd_en),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign scan_end  = (rd_idx_r == CNT_END);
  assign scan_busy = scan_end ? 1'b1 : armed_r[rd_idx_r[IDX_W-1:0]];

  assign ev_armed  = ev_vld_r && armed_r[ev_idx_r];
  assign tick_hit  = ev_armed && (mem_rdata.ticks == 8'd1);
  // a second expiry cannot be parked while the first still waits for the output
  assign stall     = (op_r == OP_TICK) && tick_hit && pend_vld_r && !out_free;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    owner_nxt       = owner_r;
    delay_nxt       = delay_r;
    action_nxt      = action_r;
    armed_nxt       = armed_r;
    rd_idx_nxt      = rd_idx_r;
    ev_vld_nxt      = ev_vld_r;
    ev_idx_nxt      = ev_idx_r;
    cnt_nxt         = cnt_r;
    full_nxt        = full_r;
    pend_vld_nxt    = pend_vld_r;
    pend_idx_nxt    = pend_idx_r;
    pend_owner_nxt  = pend_owner_r;
    pend_action_nxt = pend_action_r;
    out_vld_nxt     = out_vld_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_slot_nxt    = out_slot_r;
    out_owner_nxt   = out_owner_r;
    out_action_nxt  = out_action_r;
    out_cnt_nxt     = out_cnt_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = rd_idx_r[IDX_W-1:0];
    mem_wdata       = '0;
    mem_rd_en       = 1'b0;
    mem_raddr       = rd_idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt       = in_tuser;
          owner_nxt    = in_tdata[15:0];
          delay_nxt    = in_tdata[23:16];
          action_nxt   = in_tdata[26:24];
          rd_idx_nxt   = '0;
          ev_vld_nxt   = 1'b0;
          cnt_nxt      = '0;
          pend_vld_nxt = 1'b0;
          case (in_tuser)
            OP_SCHEDULE:         state_nxt = S_SCAN;
            OP_TICK, OP_RELEASE: state_nxt = S_WALK;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          full_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (!scan_busy) begin
          mem_we           = 1'b1;
          mem_wdata.ticks  = (delay_r == 8'd0) ? 8'd1 : delay_r;
          mem_wdata.owner  = owner_r;
          mem_wdata.action = action_r;
          armed_nxt[rd_idx_r[IDX_W-1:0]] = 1'b1;
          full_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end

      S_WALK: begin
        if (!ev_vld_r && scan_end) begin
          state_nxt = S_FIN;
        end else if (!stall) begin
          // evaluate the entry held in the read data register
          if (op_r == OP_TICK) begin
            if (tick_hit) begin
              armed_nxt[ev_idx_r] = 1'b0;
              if (pend_vld_r) begin
                out_vld_nxt    = 1'b1;
                out_kind_nxt   = KIND_EXPIRY;
                out_slot_nxt   = 4'(pend_idx_r);
                out_owner_nxt  = pend_owner_r;
                out_action_nxt = pend_action_r;
                out_cnt_nxt    = '0;
                out_last_nxt   = 1'b0;
              end
              pend_vld_nxt    = 1'b1;
              pend_idx_nxt    = ev_idx_r;
              pend_owner_nxt  = mem_rdata.owner;
              pend_action_nxt = mem_rdata.action;
            end else if (ev_armed) begin
              mem_we          = 1'b1;
              mem_waddr       = ev_idx_r;
              mem_wdata       = mem_rdata;
              mem_wdata.ticks = mem_rdata.ticks - 8'd1;
            end
          end else if (ev_armed && (mem_rdata.owner == owner_r)) begin
            armed_nxt[ev_idx_r] = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
          end
          // read the next entry
          if (!scan_end) begin
            mem_rd_en  = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt = rd_idx_r + 1'b1;
          end else begin
            ev_vld_nxt = 1'b0;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_last_nxt   = 1'b1;
          out_slot_nxt   = '0;
          out_owner_nxt  = '0;
          out_action_nxt = '0;
          out_cnt_nxt    = '0;
          case (op_r)
            OP_SCHEDULE: begin
              out_kind_nxt = full_r ? KIND_FULL : KIND_SCHEDULED;
              out_slot_nxt = full_r ? 4'd0 : 4'(rd_idx_r[IDX_W-1:0]);
            end
            OP_TICK: begin
              if (pend_vld_r) begin
                out_kind_nxt   = KIND_EXPIRY;
                out_slot_nxt   = 4'(pend_idx_r);
                out_owner_nxt  = pend_owner_r;
                out_action_nxt = pend_action_r;
              end else begin
                out_kind_nxt = KIND_IDLE_TICK;
              end
            end
            default: begin
              out_kind_nxt = KIND_RELEASED;
              out_cnt_nxt  = 5'(cnt_r);
            end
          endcase
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      armed_r    <= '0;
      ev_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      armed_r    <= armed_nxt;
      ev_vld_r   <= ev_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    owner_r       <= owner_nxt;
    delay_r       <= delay_nxt;
    action_r      <= action_nxt;
    rd_idx_r      <= rd_idx_nxt;
    ev_idx_r      <= ev_idx_nxt;
    cnt_r         <= cnt_nxt;
    full_r        <= full_nxt;
    pend_idx_r    <= pend_idx_nxt;
    pend_owner_r  <= pend_owner_nxt;
    pend_action_r <= pend_action_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_owner_r   <= out_owner_nxt;
    out_action_r  <= out_action_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_cnt_r, out_action_r, out_owner_r, out_slot_r};

endmodule

@@ hw/rtl/tst_checker.sv @@
// Port-level checks for the timer slot table, bound to the top level.
module tst_checker
  import tst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // only expiries come in runs; every other kind is a single final result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_EXPIRY) |-> out_tlast)
    else $error("non-expiry result without last");

  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_EXPIRY) |-> (out_tdata[22:4] == 19'd0))
    else $error("owner or action set on non-expiry result");

  // an unfinished run of expiries means the item is still in progress
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while an expiry run is open");

endmodule

bind timer_slot_table tst_checker u_tst_checker (.*);
